>>> design/ssl_pkg.sv
// Package for the scored sorted id list: field widths, operation, error and
// state codes, and the struct that one list cell hands to its neighbors.
// No dependencies.
`default_nettype none

package ssl_pkg;

   localparam int ID_BITS         = 8;
   localparam int ID_SPACE        = 256;
   localparam int FUNC_BITS       = 2;
   localparam int ERR_BITS        = 2;
   localparam int COUNT_BITS      = 9;
   localparam int SCORE_PORT_BITS = 32;

   typedef enum logic [FUNC_BITS-1:0] {
      OP_INSERT,
      OP_UPDATE,
      OP_REMOVE,
      OP_CLEAR
   } ssl_op_type;

   typedef enum logic [ERR_BITS-1:0] {
      ERR_OK,
      ERR_ABSENT,
      ERR_PRESENT,
      ERR_FULL
   } ssl_err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } ssl_state_type;

   // Command broadcast to every cell during the execute cycle.
   typedef struct packed {
      logic       run;
      ssl_op_type op;
   } ssl_cmd_type;

   // What a cell shows its neighbors: contents and its compares against the
   // broadcast score (ge: at or above it, gt: strictly above it).
   typedef struct packed {
      logic               valid;
      logic [ID_BITS-1:0] id;
      logic               ge;
      logic               gt;
   } ssl_link_type;

   // Virtual neighbor in front of the head cell: empty, but ranks above all.
   localparam ssl_link_type LINK_HEAD = '{valid: 1'b0, id: '0, ge: 1'b1, gt: 1'b0};
   // Virtual neighbor behind the last cell.
   localparam ssl_link_type LINK_END  = '{valid: 1'b0, id: '0, ge: 1'b0, gt: 1'b0};

endpackage

`default_nettype wire

>>> design/ssl_cell.sv
// One slot of the sorted list. Holds an id and a score and, on each
// operation, keeps its item, takes a neighbor's, takes the broadcast item or empties.
// Depends on ssl_pkg.
`default_nettype none

module ssl_cell #(
   parameter int SCORE_W = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ssl_pkg::ssl_cmd_type                cmd,
   input  logic [ssl_pkg::ID_BITS-1:0]         key_id,
   input  logic [ssl_pkg::ID_BITS-1:0]         e_id,
   input  logic signed [SCORE_W-1:0]           e_score,
   input  logic                                after_match,
   input  ssl_pkg::ssl_link_type               left_link,
   input  logic signed [SCORE_W-1:0]           left_score,
   input  ssl_pkg::ssl_link_type               right_link,
   input  logic signed [SCORE_W-1:0]           right_score,
   output ssl_pkg::ssl_link_type               cell_out,
   output logic signed [SCORE_W-1:0]           score,
   output logic                                match,
   output logic                                is_tail
);
   import ssl_pkg::*;

   logic                      valid_ff, valid_in;
   logic [ID_BITS-1:0]        id_ff, id_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic                      ge, gt, before_m, rest_here, rest_prev;

   assign ge       = valid_ff && (score_ff >= e_score);
   assign gt       = valid_ff && (score_ff > e_score);
   assign match    = valid_ff && (id_ff == key_id);
   assign is_tail  = valid_ff && !right_link.valid;
   assign before_m = !after_match && !match;

   assign cell_out = '{valid: valid_ff, id: id_ff, ge: ge, gt: gt};
   assign score    = score_ff;

   // With the acted-on item taken out, the remaining items close up: the one
   // that would sit here comes from this cell in front of the match and from
   // the right neighbor behind it. rest_here and rest_prev tell whether that
   // item, and the one a slot earlier, still rank in front of the new item.
   // Ties rank in front only when the item stood in front of the match.
   assign rest_here = before_m ? ge : right_link.gt;
   assign rest_prev = after_match ? gt : left_link.ge;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      score_in = score_ff;
      if (cmd.run) begin
         unique case (cmd.op)
            OP_INSERT, OP_UPDATE: begin
               priority if (rest_here) begin
                  if (!before_m) begin
                     valid_in = right_link.valid;
                     id_in    = right_link.id;
                     score_in = right_score;
                  end
               end else if (rest_prev) begin
                  valid_in = 1'b1;
                  id_in    = e_id;
                  score_in = e_score;
               end else if (!after_match) begin
                  valid_in = left_link.valid;
                  id_in    = left_link.id;
                  score_in = left_score;
               end else begin
                  valid_in = valid_ff;
               end
            end
            OP_REMOVE: begin
               // The tail item fills the gap and sinks past strictly larger
               // scores; it is the broadcast item here.
               if (!before_m) begin
                  priority if (is_tail) begin
                     valid_in = 1'b0;
                  end else if (right_link.gt) begin
                     valid_in = right_link.valid;
                     id_in    = right_link.id;
                     score_in = right_score;
                  end else if (match || (after_match && gt)) begin
                     valid_in = 1'b1;
                     id_in    = e_id;
                     score_in = e_score;
                  end else begin
                     valid_in = valid_ff;
                  end
               end
            end
            OP_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      score_ff <= score_in;
   end

endmodule

`default_nettype wire

>>> design/ssl_prefix.sv
// Log-depth prefix OR over the cells' id-match flags: tells each cell whether
// the matching item lies in front of it, and whether any cell matched.
// Depends on nothing.
`default_nettype none

module ssl_prefix #(
   parameter int N = 256
) (
   input  logic [N-1:0] match,
   output logic [N-1:0] after_match,
   output logic         any_match
);
   localparam int LEVELS = $clog2(N);

   logic [N-1:0] pre [LEVELS+1];

   assign pre[0] = match;

   for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
      localparam int D = 1 << k;
      assign pre[k+1][D-1:0] = pre[k][D-1:0];
      assign pre[k+1][N-1:D] = pre[k][N-1:D] | pre[k][N-1-D:0];
   end

   assign after_match = {pre[LEVELS][N-2:0], 1'b0};
   assign any_match   = pre[LEVELS][N-1];

endmodule

`default_nettype wire

>>> design/ssl_tail_pick.sv
// Picks the contents of the tail cell (the one flagged in sel) through an
// OR tree and registers them for the next remove.
// Depends on nothing.
`default_nettype none

module ssl_tail_pick #(
   parameter int N = 256,
   parameter int W = 40
) (
   input  logic         clock,
   input  logic [N-1:0] sel,
   input  logic [W-1:0] data [N],
   output logic [W-1:0] picked
);
   localparam int LEVELS = $clog2(N);
   localparam int NPAD   = 1 << LEVELS;

   logic [W-1:0] node [1:2*NPAD-1];
   logic [W-1:0] picked_ff;

   for (genvar i = 0; i < NPAD; i++) begin : g_leaf
      if (i < N) begin : g_used
         assign node[NPAD+i] = sel[i] ? data[i] : '0;
      end else begin : g_pad
         assign node[NPAD+i] = '0;
      end
   end

   for (genvar j = 1; j < NPAD; j++) begin : g_node
      assign node[j] = node[2*j] | node[2*j+1];
   end

   always_ff @(posedge clock) begin
      picked_ff <= node[1];
   end

   assign picked = picked_ff;

endmodule

`default_nettype wire

>>> design/scored_sorted_id_list.sv
// Top level of the scored sorted id list: control, id-held flags, the row of
// list cells, the match prefix and the tail register.
// Depends on ssl_pkg, ssl_cell, ssl_prefix and ssl_tail_pick.
`default_nettype none

// An item is taken when start is high and busy is low. busy is then high for
// one cycle while every cell of the row updates itself at once from its own
// compare and its neighbors, and in the following cycle rsp_strobe is high
// for exactly one cycle with the head of the list, the count and the error
// code. The receiver cannot hold results off; the outputs keep a result until
// the next item updates the row. Start may be high again in the strobe cycle,
// in which the tail register, which a remove needs, reloads from the updated
// row; a new item is taken only after the row update of the last. There is no
// clearing pass after reset; the list is usable in the first cycle.

module scored_sorted_id_list #(
   parameter int CAPACITY   = 256,
   parameter int SCORE_BITS = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [ssl_pkg::FUNC_BITS-1:0]              req_func,
   input  logic [ssl_pkg::ID_BITS-1:0]                req_id,
   input  logic signed [ssl_pkg::SCORE_PORT_BITS-1:0] req_score,
   output logic                                       rsp_strobe,
   output logic [ssl_pkg::ID_BITS-1:0]                rsp_top_id,
   output logic signed [ssl_pkg::SCORE_PORT_BITS-1:0] rsp_top_score,
   output logic [ssl_pkg::COUNT_BITS-1:0]             rsp_count,
   output logic [ssl_pkg::ERR_BITS-1:0]               rsp_error
);
   import ssl_pkg::*;

   localparam int KEEP_BITS  = (SCORE_BITS < SCORE_PORT_BITS) ? SCORE_BITS : SCORE_PORT_BITS;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int ENTRY_BITS = ID_BITS + KEEP_BITS;

   ssl_state_type               state_ff, state_in;
   ssl_op_type                  func_ff;
   logic [ID_BITS-1:0]          id_ff;
   logic signed [KEEP_BITS-1:0] score_ff;
   logic                        held_hit_ff;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   ssl_err_type                 err_ff, err_now;
   logic [ID_SPACE-1:0]         held_ff, held_in;

   logic                        accept;
   ssl_cmd_type                 cmd;
   logic [ID_BITS-1:0]          e_id;
   logic signed [KEEP_BITS-1:0] e_score;
   logic [ENTRY_BITS-1:0]       tail_entry;
   logic [ID_BITS-1:0]          tail_id;
   logic signed [KEEP_BITS-1:0] tail_score;

   ssl_link_type                cell_out    [CAPACITY];
   logic signed [KEEP_BITS-1:0] cell_score  [CAPACITY];
   ssl_link_type                nb_left     [CAPACITY];
   logic signed [KEEP_BITS-1:0] sc_left     [CAPACITY];
   ssl_link_type                nb_right    [CAPACITY];
   logic signed [KEEP_BITS-1:0] sc_right    [CAPACITY];
   logic [ENTRY_BITS-1:0]       tail_data   [CAPACITY];
   logic [CAPACITY-1:0]         cell_match;
   logic [CAPACITY-1:0]         cell_tail;
   logic [CAPACITY-1:0]         after_match;
   logic                        any_match;

   assign accept = start && !busy;

   // ---------------- control ----------------
   always_comb begin
      unique case (state_ff)
         ST_IDLE, ST_DONE: state_in = accept ? ST_EXEC : ST_IDLE;
         ST_EXEC:          state_in = ST_DONE;
         default:          state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b0;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_EXEC: busy       = 1'b1;
         ST_DONE: rsp_strobe = 1'b1;
         default: busy       = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The held flag is looked up as the item is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff     <= ssl_op_type'(req_func);
         id_ff       <= req_id;
         score_ff    <= req_score[KEEP_BITS-1:0];
         held_hit_ff <= held_ff[req_id];
      end
   end

   always_comb begin
      unique case (func_ff)
         OP_INSERT: begin
            priority if (held_hit_ff) begin
               err_now = ERR_PRESENT;
            end else if (count_ff >= CNT_BITS'(CAPACITY)) begin
               err_now = ERR_FULL;
            end else begin
               err_now = ERR_OK;
            end
         end
         OP_UPDATE, OP_REMOVE: err_now = held_hit_ff ? ERR_OK : ERR_ABSENT;
         OP_CLEAR:             err_now = ERR_OK;
         default:              err_now = ERR_OK;
      endcase
   end

   assign cmd.run = (state_ff == ST_EXEC) && (err_now == ERR_OK);
   assign cmd.op  = func_ff;

   assign tail_id    = tail_entry[ENTRY_BITS-1 -: ID_BITS];
   assign tail_score = tail_entry[KEEP_BITS-1:0];
   assign e_id       = (func_ff == OP_REMOVE) ? tail_id : id_ff;
   assign e_score    = (func_ff == OP_REMOVE) ? tail_score : score_ff;

   always_comb begin
      count_in = count_ff;
      held_in  = held_ff;
      if (cmd.run) begin
         unique case (cmd.op)
            OP_INSERT: begin
               count_in       = count_ff + CNT_BITS'(1);
               held_in[id_ff] = 1'b1;
            end
            OP_REMOVE: begin
               count_in       = count_ff - CNT_BITS'(1);
               held_in[id_ff] = 1'b0;
            end
            OP_CLEAR: begin
               count_in = '0;
               held_in  = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= '0;
         err_ff   <= ERR_OK;
      end else begin
         count_ff <= count_in;
         held_ff  <= held_in;
         if (state_ff == ST_EXEC) begin
            err_ff <= err_now;
         end
      end
   end

   // ---------------- cell row ----------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign nb_left[i] = LINK_HEAD;
         assign sc_left[i] = '0;
      end else begin : g_left
         assign nb_left[i] = cell_out[i-1];
         assign sc_left[i] = cell_score[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
         assign nb_right[i] = LINK_END;
         assign sc_right[i] = '0;
      end else begin : g_right
         assign nb_right[i] = cell_out[i+1];
         assign sc_right[i] = cell_score[i+1];
      end

      ssl_cell #(
         .SCORE_W (KEEP_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key_id      (id_ff),
         .e_id        (e_id),
         .e_score     (e_score),
         .after_match (after_match[i]),
         .left_link   (nb_left[i]),
         .left_score  (sc_left[i]),
         .right_link  (nb_right[i]),
         .right_score (sc_right[i]),
         .cell_out    (cell_out[i]),
         .score       (cell_score[i]),
         .match       (cell_match[i]),
         .is_tail     (cell_tail[i])
      );

      assign tail_data[i] = {cell_out[i].id, cell_score[i]};
   end

   ssl_prefix #(
      .N (CAPACITY)
   ) u_prefix (
      .match       (cell_match),
      .after_match (after_match),
      .any_match   (any_match)
   );

   ssl_tail_pick #(
      .N (CAPACITY),
      .W (ENTRY_BITS)
   ) u_tail (
      .clock  (clock),
      .sel    (cell_tail),
      .data   (tail_data),
      .picked (tail_entry)
   );

   // ---------------- result ----------------
   assign rsp_top_id    = cell_out[0].valid ? cell_out[0].id : '0;
   assign rsp_top_score = cell_out[0].valid ? SCORE_PORT_BITS'(cell_score[0]) : '0;
   assign rsp_count     = COUNT_BITS'(count_ff);
   assign rsp_error     = err_ff;

   // ---------------- assertions ----------------
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an item was taken");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("result strobe missing two cycles after an item was taken");

   a_held_vs_count: assert property (@(posedge clock) disable iff (reset)
      $countones(held_ff) == int'(count_ff))
      else $error("held id flags disagree with the entry count");

   a_cells_agree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (any_match == held_hit_ff))
      else $error("held flag disagrees with the ids held in the cells");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (cell_out[0].valid == (count_ff != '0)))
      else $error("head cell occupancy disagrees with the count");

endmodule

`default_nettype wire
